@@ hw/rtl/sccc_pkg.sv @@
`timescale 1ns / 1ps
package sccc_pkg;

  localparam int NUM_SETS_DEF   = 256;
  localparam int NUM_WAYS_DEF   = 4;
  localparam int LINE_BYTES_DEF = 64;
  localparam int ADDR_W         = 32;
  localparam int LINE_ADDR_W    = 26;
  localparam int STAMP_W        = 32;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_SNOOP = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    BUS_NONE  = 2'd0,
    BUS_RD    = 2'd1,
    BUS_RDX   = 2'd2,
    BUS_UPGR  = 2'd3
  } bus_cmd_t;

  typedef enum logic [1:0] {
    LS_I = 2'd0,
    LS_S = 2'd1,
    LS_E = 2'd2,
    LS_M = 2'd3
  } line_st_t;

  typedef enum logic [1:0] {
    RPL_NONE  = 2'd0,
    RPL_FLUSH = 2'd1,
    RPL_OPT   = 2'd2
  } reply_t;

  localparam logic [1:0] MODE_MSI  = 2'd0;
  localparam logic [1:0] MODE_UPGR = 2'd1;
  localparam logic [1:0] MODE_MESI = 2'd2;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_UPDATE,
    BK_CLEAR
  } bk_state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] address;
    logic [1:0]  bus_command;
    logic        only_copy;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [1:0]  bus_request;
    logic [1:0]  snoop_reply;
    logic        victim_writeback;
    logic [25:0] victim_line_address;
    logic        intervention;
    logic        invalidation;
  } out_item_t;

endpackage

@@ hw/rtl/sccc_front.sv @@
`timescale 1ns / 1ps
// Front end: accept items, classify, hold in a two-entry queue.
module sccc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  sccc_pkg::in_item_t in_item,
  output logic               q_valid,
  input  logic               q_take,
  output sccc_pkg::in_item_t q_item,
  output logic               q_access
);

  sccc_pkg::in_item_t buf_item [2];
  logic               rd_ptr, wr_ptr;
  logic [1:0]         count;

  assign full     = (count == 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = buf_item[rd_ptr];
  assign q_access = (q_item.operation == sccc_pkg::OP_READ) ||
                    (q_item.operation == sccc_pkg::OP_WRITE);

  // Store incoming transfer
  always_ff @(posedge clk) begin
    if (push && !full) begin
      buf_item[wr_ptr] <= in_item;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (q_take && q_valid) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push && !full} - {1'b0, q_take && q_valid};
    end
  end

endmodule

@@ hw/rtl/sccc_back.sv @@
`timescale 1ns / 1ps
// Back end: set memory read, compare, update, result register.
module sccc_back #(
  parameter int NUM_SETS   = sccc_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS   = sccc_pkg::NUM_WAYS_DEF,
  parameter int LINE_BYTES = sccc_pkg::LINE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          protocol_mode,
  input  logic                q_valid,
  output logic                q_take,
  input  sccc_pkg::in_item_t  q_item,
  input  logic                q_access,
  output logic                empty,
  input  logic                pop,
  output sccc_pkg::out_item_t out_item
);

  localparam int OFF_W  = $clog2(LINE_BYTES);
  localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int SET_B  = $clog2(NUM_SETS);
  localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int TAG_W  = sccc_pkg::ADDR_W - OFF_W - SET_B;
  localparam int LA_W   = sccc_pkg::ADDR_W - OFF_W;
  localparam int SW     = sccc_pkg::STAMP_W;
  localparam int ROW_W  = NUM_WAYS * (TAG_W + 2 + SW);

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [1:0]       st;
    logic [SW-1:0]    stamp;
  } way_t;

  // One row per set
  way_t [NUM_WAYS-1:0]  row_rd, row_wr;
  logic [SET_W-1:0]     clr_idx;
  logic                 row_we;
  logic [SET_W-1:0]     row_addr;

  sccc_pkg::bk_state_t  state, state_next;
  sccc_pkg::in_item_t   cur;
  logic                 cur_access;
  logic [SW-1:0]        access_count;
  sccc_pkg::out_item_t  res, res_next;
  logic                 res_valid;

  logic [LA_W-1:0]  line_addr;
  logic [SET_W-1:0] cur_set;
  logic [TAG_W-1:0] cur_tag;
  logic             mesi;

  assign line_addr = cur.address[sccc_pkg::ADDR_W-1:OFF_W];
  if (NUM_SETS > 1) begin : g_set
    assign cur_set = line_addr[SET_W-1:0];
  end else begin : g_noset
    assign cur_set = '0;
  end
  assign cur_tag = line_addr[LA_W-1:LA_W-TAG_W];
  assign mesi    = (protocol_mode != sccc_pkg::MODE_MSI) &&
                   (protocol_mode != sccc_pkg::MODE_UPGR);

  // Row memory: one port, registered read
  logic [NUM_WAYS*(TAG_W+2+SW)-1:0] mem_q;
  logic [ROW_W-1:0] mem_arr [NUM_SETS];
  always_ff @(posedge clk) begin
    if (row_we) mem_arr[row_addr] <= row_wr;
    else        mem_q <= mem_arr[row_addr];
  end
  assign row_rd = mem_q;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      sccc_pkg::BK_CLEAR:
        if (clr_idx == SET_W'(NUM_SETS - 1)) state_next = sccc_pkg::BK_IDLE;
      sccc_pkg::BK_IDLE:
        if (q_valid && !(res_valid && !pop)) state_next = sccc_pkg::BK_READ;
      sccc_pkg::BK_READ:   state_next = sccc_pkg::BK_UPDATE;
      sccc_pkg::BK_UPDATE: state_next = sccc_pkg::BK_IDLE;
      default:             state_next = sccc_pkg::BK_IDLE;
    endcase
  end

  assign q_take = (state == sccc_pkg::BK_IDLE) && q_valid && !(res_valid && !pop);

  // Lookup and update
  logic [WAY_W-1:0] hit_way, vic_way, inv_way, lru_way, sel;
  logic             hit, any_inv;
  logic [SW-1:0]    mn, new_count;
  always_comb begin
    hit = 1'b0; hit_way = '0; any_inv = 1'b0; inv_way = '0;
    lru_way = '0; mn = row_rd[0].stamp;
    for (int w = NUM_WAYS-1; w >= 0; w--) begin
      if (row_rd[w].st != sccc_pkg::LS_I && row_rd[w].tag == cur_tag) begin
        hit = 1'b1; hit_way = WAY_W'(w);
      end
      if (row_rd[w].st == sccc_pkg::LS_I) begin
        any_inv = 1'b1; inv_way = WAY_W'(w);
      end
    end
    for (int w = 1; w < NUM_WAYS; w++) begin
      if (row_rd[w].stamp <= mn) begin
        lru_way = WAY_W'(w); mn = row_rd[w].stamp;
      end
    end
    vic_way = any_inv ? inv_way : lru_way;
  end

  always_comb begin
    logic [1:0] st;
    logic [LA_W-1:0] va;
    new_count = access_count + SW'(1);
    row_wr    = row_rd;
    res_next  = '0;
    sel       = hit ? hit_way : vic_way;
    st        = row_rd[sel].st;
    va        = '0;
    row_we    = 1'b0;
    row_addr  = cur_set;
    if (state == sccc_pkg::BK_CLEAR) begin
      row_we   = 1'b1;
      row_addr = clr_idx;
      row_wr   = '0;
    end else if (state == sccc_pkg::BK_IDLE) begin
      row_addr = SET_W'(q_item.address[sccc_pkg::ADDR_W-1:OFF_W]);
      if (NUM_SETS == 1) row_addr = '0;
    end else if (state == sccc_pkg::BK_UPDATE) begin
      if (cur_access) begin
        row_we = 1'b1;
        res_next.hit = hit;
        if (!hit) begin
          if (st == sccc_pkg::LS_M) begin
            res_next.victim_writeback = 1'b1;
            va = LA_W'({row_rd[sel].tag, cur_set}) ;
            if (NUM_SETS == 1) va = LA_W'(row_rd[sel].tag);
            res_next.victim_line_address = va[sccc_pkg::LINE_ADDR_W-1:0];
          end
          row_wr[sel].tag = cur_tag;
          st = sccc_pkg::LS_I;
        end
        row_wr[sel].stamp = new_count;
        if (cur.operation == sccc_pkg::OP_READ) begin
          if (st == sccc_pkg::LS_I) begin
            row_wr[sel].st = (mesi && cur.only_copy) ? sccc_pkg::LS_E : sccc_pkg::LS_S;
            res_next.bus_request = sccc_pkg::BUS_RD;
          end else row_wr[sel].st = st;
        end else begin
          case (st)
            sccc_pkg::LS_I: res_next.bus_request = sccc_pkg::BUS_RDX;
            sccc_pkg::LS_S: res_next.bus_request =
              (protocol_mode == sccc_pkg::MODE_MSI) ? sccc_pkg::BUS_RDX : sccc_pkg::BUS_UPGR;
            default: ;
          endcase
          row_wr[sel].st = sccc_pkg::LS_M;
        end
      end else if (cur.operation == sccc_pkg::OP_SNOOP && hit) begin
        row_we = 1'b1;
        res_next.hit = 1'b1;
        case (cur.bus_command)
          sccc_pkg::BUS_RD: begin
            if (st == sccc_pkg::LS_M) begin
              res_next.snoop_reply = sccc_pkg::RPL_FLUSH;
              res_next.intervention = 1'b1; row_wr[sel].st = sccc_pkg::LS_S;
            end else if (st == sccc_pkg::LS_E) begin
              res_next.snoop_reply = sccc_pkg::RPL_OPT;
              res_next.intervention = 1'b1; row_wr[sel].st = sccc_pkg::LS_S;
            end else if (mesi) res_next.snoop_reply = sccc_pkg::RPL_OPT;
          end
          sccc_pkg::BUS_RDX: begin
            if (st == sccc_pkg::LS_M) res_next.snoop_reply = sccc_pkg::RPL_FLUSH;
            else if (st == sccc_pkg::LS_E || mesi) res_next.snoop_reply = sccc_pkg::RPL_OPT;
            row_wr[sel].st = sccc_pkg::LS_I;
            res_next.invalidation = 1'b1;
          end
          sccc_pkg::BUS_UPGR: begin
            if (st == sccc_pkg::LS_S) begin
              row_wr[sel].st = sccc_pkg::LS_I;
              res_next.invalidation = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sccc_pkg::BK_CLEAR;
      clr_idx      <= '0;
      access_count <= '0;
      res_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == sccc_pkg::BK_CLEAR) clr_idx <= clr_idx + SET_W'(1);
      if (state == sccc_pkg::BK_UPDATE && cur_access) access_count <= new_count;
      if (state == sccc_pkg::BK_UPDATE) res_valid <= 1'b1;
      else if (pop && res_valid) res_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (q_take) begin
      cur        <= q_item;
      cur_access <= q_access;
    end
    if (state == sccc_pkg::BK_UPDATE) res <= res_next;
  end

  assign empty    = !res_valid;
  assign out_item = res;

endmodule

@@ hw/rtl/snoopy_coherent_cache_controller_core.sv @@
`timescale 1ns / 1ps
// Channel   Handshake     Payload
// input     push / full   in_item   (operation, address, bus_command, only_copy)
// result    pop / empty   out_item  (hit, bus_request, snoop_reply, ...)
// config    cfg_we        cfg_data  (protocol_mode)
// Each item passes three back-end steps: issue, set row read, row update, and
// no new item is taken before the update. The single-port set memory (one row
// of all ways) sets this order. After reset a clearing pass writes every set
// row; full stays high meanwhile once the two-entry queue fills. A waiting
// result stalls the back end; the queue then fills and raises full.
module snoopy_coherent_cache_controller_core #(
  parameter int NUM_SETS   = sccc_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS   = sccc_pkg::NUM_WAYS_DEF,
  parameter int LINE_BYTES = sccc_pkg::LINE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  sccc_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output sccc_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_data
);

  logic [1:0]         protocol_mode;
  logic               q_valid, q_take, q_access;
  sccc_pkg::in_item_t q_item;

  // Hold mode register
  always_ff @(posedge clk) begin
    if (rst) protocol_mode <= sccc_pkg::MODE_MESI;
    else if (cfg_we) protocol_mode <= cfg_data;
  end

  sccc_front u_front (
    .clk, .rst, .push, .full, .in_item,
    .q_valid, .q_take, .q_item, .q_access
  );

  sccc_back #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .LINE_BYTES(LINE_BYTES)) u_back (
    .clk, .rst, .protocol_mode, .q_valid, .q_take, .q_item, .q_access,
    .empty, .pop, .out_item
  );

endmodule

@@ hw/rtl/sccc_checker.sv @@
`timescale 1ns / 1ps
module sccc_checker (
  input logic                clk,
  input logic                rst,
  input logic                empty,
  input logic                pop,
  input sccc_pkg::out_item_t out_item
);

  // Held result does not change before transfer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(out_item)) else $error("result changed");

  // No writeback without a miss
  a_wb: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.victim_writeback) |-> !out_item.hit) else $error("wb on hit");

  // Snoop fields and bus request are exclusive
  a_excl: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.bus_request != sccc_pkg::BUS_NONE) |->
      (out_item.snoop_reply == sccc_pkg::RPL_NONE && !out_item.intervention &&
       !out_item.invalidation))
    else $error("mixed result");

  // Address zero without writeback
  a_va: assert property (@(posedge clk) disable iff (rst)
    (!empty && !out_item.victim_writeback) |-> out_item.victim_line_address == '0)
    else $error("stray address");

endmodule

bind snoopy_coherent_cache_controller_core sccc_checker u_chk (
  .clk, .rst, .empty, .pop, .out_item
);
